### rtl/core/nstp_pkg.sv
`default_nettype none

package nstp_pkg;

  // Field widths
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CAT_W      = 3;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LVL_W      = 4;
  localparam int unsigned FRAME_W    = CAT_W + TIME_W;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 200;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_ENTER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EXIT  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH,
    ST_DONE
  } state_t;

  // Datapath operation in the execute cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ENTER,
    OP_OVER,
    OP_EXIT,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic capture;
    op_t  op;
    logic push;
    logic load_out;
  } nstp_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             cat_ok;
    logic             empty;
    logic             full;
  } nstp_sts_t;

endpackage

`default_nettype wire

### rtl/core/nstp_ram.sv
`default_nettype none

module nstp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/nstp_ctrl.sv
`default_nettype none

module nstp_ctrl
  import nstp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire nstp_sts_t sts,
  output nstp_cmd_t      cmd
);

  state_t state, state_next;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.req == REQ_ENTER && sts.cat_ok && !sts.full) begin
          state_next = ST_PUSH;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_PUSH: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.op       = OP_NONE;
    cmd.push     = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        case (sts.req)
          REQ_ENTER: begin
            if (sts.cat_ok) cmd.op = sts.full ? OP_OVER : OP_ENTER;
          end
          REQ_EXIT: begin
            if (!sts.empty) cmd.op = OP_EXIT;
          end
          REQ_CLEAR: cmd.op = OP_CLEAR;
          REQ_QUERY: cmd.op = OP_NONE;
          default:   cmd.op = OP_NONE;
        endcase
      end
      ST_PUSH: cmd.push = 1'b1;
      ST_DONE: cmd.load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/nstp_dp.sv
`default_nettype none

module nstp_dp
  import nstp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH    = 8,
  parameter int unsigned NUM_CATEGORIES = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire nstp_cmd_t             cmd,
  output nstp_sts_t                  sts,
  input  wire logic [REQ_W-1:0]      req_type,
  input  wire logic [CAT_W-1:0]      category,
  input  wire logic [TIME_W-1:0]     now_us,
  output logic      [OUT_DATA_W-1:0] out_data
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
  localparam logic [CAT_W:0] NCAT = (CAT_W + 1)'(NUM_CATEGORIES);
  localparam logic [LW-1:0]  FULL_LVL = LW'(STACK_DEPTH);

  // Captured item
  logic [REQ_W-1:0]  req_q;
  logic [CAT_W-1:0]  cat_q;
  logic [TIME_W-1:0] now_q;

  // Profiler state
  logic [LW-1:0]     open_frames;
  logic [TIME_W-1:0] last_stamp;
  logic [TIME_W-1:0] window_start;
  logic [TIME_W-1:0] overflow_total;
  logic [TIME_W-1:0] cat_total [NUM_CATEGORIES];
  logic [TIME_W-1:0] cat_calls [NUM_CATEGORIES];
  logic [TIME_W-1:0] cat_max   [NUM_CATEGORIES];

  // Per-item result
  logic [CAT_W-1:0]  report_q;
  logic [TIME_W-1:0] frame_q;
  logic              acc_q;

  // Frame stack
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [FRAME_W-1:0] ram_wdata;
  logic [FRAME_W-1:0] ram_rdata;
  logic [AW-1:0]      top_addr;
  logic [CAT_W-1:0]   top_cat;
  logic [TIME_W-1:0]  top_self;
  logic [TIME_W-1:0]  charged;
  logic               top_ok;
  logic [CW-1:0]      top_idx;

  assign top_addr = AW'(open_frames - LW'(1));
  assign top_cat  = ram_rdata[CAT_W-1:0];
  assign top_self = ram_rdata[FRAME_W-1:CAT_W];
  assign charged  = top_self + (now_q - last_stamp);
  assign top_ok   = {1'b0, top_cat} < NCAT;
  assign top_idx  = CW'(top_cat);

  nstp_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.capture),
    .raddr(top_addr),
    .rdata(ram_rdata)
  );

  // Stack write: charge the top frame when an enter executes, new frame on push
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = top_addr;
    ram_wdata = {charged, top_cat};
    if (cmd.push) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(open_frames);
      ram_wdata = {{TIME_W{1'b0}}, cat_q};
    end else if ((cmd.op == OP_ENTER || cmd.op == OP_OVER) && open_frames != '0) begin
      ram_we = 1'b1;
    end
  end

  // Status to the controller
  assign sts.req    = req_q;
  assign sts.cat_ok = {1'b0, cat_q} < NCAT;
  assign sts.empty  = open_frames == '0;
  assign sts.full   = open_frames >= FULL_LVL;

  // Capture registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type;
      cat_q <= category;
      now_q <= now_us;
    end
  end

  // Profiler state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      open_frames    <= '0;
      last_stamp     <= '0;
      window_start   <= '0;
      overflow_total <= '0;
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
        cat_total[i] <= '0;
        cat_calls[i] <= '0;
        cat_max[i]   <= '0;
      end
    end else begin
      case (cmd.op)
        OP_ENTER: last_stamp <= now_q;
        OP_OVER: begin
          last_stamp     <= now_q;
          overflow_total <= overflow_total + TIME_W'(1);
        end
        OP_EXIT: begin
          last_stamp  <= now_q;
          open_frames <= open_frames - LW'(1);
          if (top_ok) begin
            cat_total[top_idx] <= cat_total[top_idx] + charged;
            cat_calls[top_idx] <= cat_calls[top_idx] + TIME_W'(1);
            if (charged > cat_max[top_idx]) cat_max[top_idx] <= charged;
          end
        end
        OP_CLEAR: begin
          open_frames    <= '0;
          overflow_total <= '0;
          window_start   <= now_q;
          last_stamp     <= now_q;
          for (int i = 0; i < NUM_CATEGORIES; i++) begin
            cat_total[i] <= '0;
            cat_calls[i] <= '0;
            cat_max[i]   <= '0;
          end
        end
        default: ;
      endcase
      if (cmd.push) begin
        open_frames <= open_frames + LW'(1);
      end
    end
  end

  // Per-item result registers: defaults on capture, updated in the execute cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      report_q <= category;
      frame_q  <= '0;
      acc_q    <= 1'b0;
    end else begin
      case (cmd.op)
        OP_ENTER, OP_OVER, OP_CLEAR: acc_q <= 1'b1;
        OP_EXIT: begin
          acc_q    <= 1'b1;
          report_q <= top_cat;
          frame_q  <= charged;
        end
        default: ;
      endcase
    end
  end

  // Result beat assembly and output register
  logic              rep_ok;
  logic [CW-1:0]     rep_idx;
  logic [TIME_W-1:0] rep_total;
  logic [TIME_W-1:0] rep_calls;
  logic [TIME_W-1:0] rep_max;

  assign rep_ok    = {1'b0, report_q} < NCAT;
  assign rep_idx   = CW'(report_q);
  assign rep_total = rep_ok ? cat_total[rep_idx] : '0;
  assign rep_calls = rep_ok ? cat_calls[rep_idx] : '0;
  assign rep_max   = rep_ok ? cat_max[rep_idx]   : '0;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {acc_q, overflow_total, LVL_W'(open_frames),
                   now_q - window_start, frame_q, rep_max, rep_calls,
                   rep_total, report_q};
    end
  end

endmodule

`default_nettype wire

### rtl/core/nested_self_time_profiler_top.sv
// Nested self-time profiler.
// Input stream (s_axis_*): one beat per event; tuser carries the request
// kind (enter, exit, clear statistics, query), tdata the category and the
// microsecond timestamp. Output stream (m_axis_*): exactly one result beat
// per input beat, in order, carrying the reported category's statistics,
// the popped frame's self time, window time, stack level, overflow count
// and an accepted flag.
// Timing: an input beat is taken in the idle cycle, the frame-stack RAM
// read of the top frame returns the next cycle, where the charge and the
// statistics update happen; an enter that opens a frame then passes
// through a push state, writing the new frame through the single RAM
// write port. The result is loaded in the done state, and the next beat
// is taken back in the idle state. The result stays in an output
// register, so the next beat can be taken while it waits; when the
// receiver stalls with a result still held, the following result waits
// in the controller and the input is not taken until it can be loaded.
// Reset (rst, synchronous) empties the stack, zeroes all statistics,
// timestamps and the overflow count, and drops any pending result.
`default_nettype none

module nested_self_time_profiler_top
  import nstp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH    = 8,
  parameter int unsigned NUM_CATEGORIES = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [2:0] category, [34:3] now_us, [39:35] zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  wire logic [REQ_W-1:0]      s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [2:0] report_category, [34:3] total_time, [66:35] call_count,
  // [98:67] max_time, [130:99] frame_time, [162:131] window_time,
  // [166:163] stack_level, [198:167] overflow_count, [199] accepted
  output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

  nstp_cmd_t cmd;
  nstp_sts_t sts;

  nstp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nstp_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .NUM_CATEGORIES(NUM_CATEGORIES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .req_type(s_axis_tuser),
    .category(s_axis_tdata[CAT_W-1:0]),
    .now_us  (s_axis_tdata[CAT_W+TIME_W-1:CAT_W]),
    .out_data(m_axis_tdata)
  );

endmodule

`default_nettype wire

### tb/nested_self_time_profiler_top_tb.sv
`timescale 1ns / 1ps

module nested_self_time_profiler_top_tb;
  import nstp_pkg::*;

  localparam int unsigned STACK_DEPTH    = 8;
  localparam int unsigned NUM_CATEGORIES = 6;
  localparam int          EVENT_GOAL     = 2000;

  // One request beat; packed so that it matches the tdata layout order
  typedef struct packed {
    logic [TIME_W-1:0] now_us;
    logic [CAT_W-1:0]  cat;
    logic [REQ_W-1:0]  req;
  } prof_req_t;

  // One report beat, highest field first, exactly as on m_axis_tdata
  typedef struct packed {
    logic              accepted;
    logic [TIME_W-1:0] overflow_count;
    logic [LVL_W-1:0]  stack_level;
    logic [TIME_W-1:0] window_time;
    logic [TIME_W-1:0] frame_time;
    logic [TIME_W-1:0] max_time;
    logic [TIME_W-1:0] call_count;
    logic [TIME_W-1:0] total_time;
    logic [CAT_W-1:0]  report_category;
  } prof_report_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [REQ_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  nested_self_time_profiler_top #(
    .STACK_DEPTH    (STACK_DEPTH),
    .NUM_CATEGORIES (NUM_CATEGORIES)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // Profiler state as predicted by the testbench
  logic [CAT_W-1:0]  stk_cat  [STACK_DEPTH];
  logic [TIME_W-1:0] stk_self [STACK_DEPTH];
  int unsigned       open_cnt = 0;
  logic [TIME_W-1:0] last_stamp   = '0;
  logic [TIME_W-1:0] window_start = '0;
  logic [TIME_W-1:0] cat_total [NUM_CATEGORIES];
  logic [TIME_W-1:0] cat_calls [NUM_CATEGORIES];
  logic [TIME_W-1:0] cat_max   [NUM_CATEGORIES];
  logic [TIME_W-1:0] refused_enters = '0;

  prof_req_t    pending_events [$];
  prof_report_t expected_reports [$];

  int mismatches    = 0;
  int n_reports     = 0;
  int n_changes     = 0;
  int n_pops        = 0;

  initial begin
    for (int i = 0; i < NUM_CATEGORIES; i++) begin
      cat_total[i] = '0;
      cat_calls[i] = '0;
      cat_max[i]   = '0;
    end
  end

  // Charge elapsed time to the top frame and move the transition stamp
  function automatic void bill_top_frame(input logic [TIME_W-1:0] now);
    if (open_cnt > 0 && open_cnt <= STACK_DEPTH)
      stk_self[open_cnt-1] = stk_self[open_cnt-1] + (now - last_stamp);
    last_stamp = now;
  endfunction

  // Apply one request to the predicted state and build its report
  function automatic prof_report_t profile_event(input prof_req_t ev);
    prof_report_t      rep;
    logic [CAT_W-1:0]  rcat;
    logic [CAT_W-1:0]  c;
    logic [TIME_W-1:0] popped;
    logic              acc;
    rcat   = ev.cat;
    popped = '0;
    acc    = 1'b0;
    case (ev.req)
      REQ_ENTER: begin
        if (ev.cat < NUM_CATEGORIES) begin
          acc = 1'b1;
          bill_top_frame(ev.now_us);
          if (open_cnt >= STACK_DEPTH) begin
            refused_enters = refused_enters + 1;
          end else begin
            stk_cat[open_cnt]  = ev.cat;
            stk_self[open_cnt] = '0;
            open_cnt++;
          end
        end
      end
      REQ_EXIT: begin
        if (open_cnt > 0 && open_cnt <= STACK_DEPTH) begin
          acc = 1'b1;
          bill_top_frame(ev.now_us);
          open_cnt--;
          n_pops++;
          c      = stk_cat[open_cnt];
          popped = stk_self[open_cnt];
          rcat   = c;
          if (c < NUM_CATEGORIES) begin
            cat_total[c] = cat_total[c] + popped;
            cat_calls[c] = cat_calls[c] + 1;
            if (popped > cat_max[c])
              cat_max[c] = popped;
          end
        end
      end
      REQ_CLEAR: begin
        acc = 1'b1;
        for (int i = 0; i < NUM_CATEGORIES; i++) begin
          cat_total[i] = '0;
          cat_calls[i] = '0;
          cat_max[i]   = '0;
        end
        open_cnt       = 0;
        refused_enters = '0;
        window_start   = ev.now_us;
        last_stamp     = ev.now_us;
      end
      default: ;
    endcase
    rep.report_category = rcat;
    if (rcat < NUM_CATEGORIES) begin
      rep.total_time = cat_total[rcat];
      rep.call_count = cat_calls[rcat];
      rep.max_time   = cat_max[rcat];
    end else begin
      rep.total_time = '0;
      rep.call_count = '0;
      rep.max_time   = '0;
    end
    rep.frame_time     = popped;
    rep.window_time    = ev.now_us - window_start;
    rep.stack_level    = open_cnt[LVL_W-1:0];
    rep.overflow_count = refused_enters;
    rep.accepted       = acc;
    return rep;
  endfunction

  // Stimulus building: timestamps advance by a delta per event
  logic [TIME_W-1:0] stamp_us   = '0;
  int                gen_depth  = 0;
  int                gen_events = 0;

  task automatic queue_event(input logic [REQ_W-1:0] req, input int unsigned cat,
                             input logic [TIME_W-1:0] dt);
    prof_req_t ev;
    stamp_us  = stamp_us + dt;
    ev.req    = req;
    ev.cat    = cat[CAT_W-1:0];
    ev.now_us = stamp_us;
    pending_events.push_back(ev);
    // track nesting only to shape the stimulus
    case (req)
      REQ_ENTER: if (cat < NUM_CATEGORIES) begin
        gen_events++;
        if (gen_depth < STACK_DEPTH) gen_depth++;
      end
      REQ_EXIT: if (gen_depth > 0) begin
        gen_events++;
        gen_depth--;
      end
      REQ_CLEAR: begin
        gen_events++;
        gen_depth = 0;
      end
      default: ;
    endcase
  endtask

  function automatic logic [TIME_W-1:0] next_delta();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 500);
    if (r < 90) return $urandom_range(0, 100000);
    return $urandom();
  endfunction

  function automatic int unsigned valid_cat();
    return $urandom_range(0, NUM_CATEGORIES - 1);
  endfunction

  initial begin
    int unsigned r;
    int unsigned len;
    int unsigned q;
    bit          deep;

    // Directed: empty stats, ignored requests, full stack, wrapping times
    queue_event(REQ_QUERY, 0, 100);
    queue_event(REQ_QUERY, 7, 3);
    queue_event(REQ_EXIT, 0, 5);
    queue_event(REQ_ENTER, 6, 9);
    queue_event(REQ_ENTER, 7, 9);
    queue_event(REQ_CLEAR, 0, 32'hFFFF_FFF0 - stamp_us);
    for (int unsigned c = 0; c < NUM_CATEGORIES; c++)
      queue_event(REQ_ENTER, c, (c == 1) ? 32'd0 : 32'd7 + c);
    queue_event(REQ_ENTER, 0, 40);
    queue_event(REQ_ENTER, 1, 32'hFFFF_FFFF);
    queue_event(REQ_ENTER, 2, 32'h8000_0000);
    queue_event(REQ_ENTER, 5, 0);
    queue_event(REQ_EXIT, 0, 32'hFFFF_FFFF);
    queue_event(REQ_EXIT, 0, 32'h8000_0001);
    for (int i = 0; i < STACK_DEPTH - 2; i++)
      queue_event(REQ_EXIT, 0, i * 13);
    queue_event(REQ_EXIT, 0, 2);
    queue_event(REQ_QUERY, 5, 1);
    queue_event(REQ_QUERY, 6, 1);
    queue_event(REQ_CLEAR, 0, 32'd0 - stamp_us);

    // Random sessions: mostly well-nested frames, some noise and misuse
    while (gen_events < EVENT_GOAL) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        len  = $urandom_range(4, 40);
        deep = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < len; i++) begin
          q = $urandom_range(0, 99);
          if (q < 8)
            queue_event(REQ_QUERY, $urandom_range(0, 7), next_delta());
          else if (gen_depth == 0 || q < (deep ? 75 : 50))
            queue_event(REQ_ENTER, valid_cat(), next_delta());
          else
            queue_event(REQ_EXIT, $urandom_range(0, 7), next_delta());
        end
        while (gen_depth > 0)
          queue_event(REQ_EXIT, 0, next_delta());
      end else if (r < 84) begin
        len = $urandom_range(1, 8);
        for (int unsigned i = 0; i < len; i++)
          queue_event($urandom_range(0, 3), $urandom_range(0, 7), $urandom());
      end else if (r < 93) begin
        // misuse: bad categories, exits past the bottom, frames left open
        queue_event(REQ_ENTER, $urandom_range(NUM_CATEGORIES, 7), next_delta());
        len = $urandom_range(0, 3);
        for (int unsigned i = 0; i < len; i++)
          queue_event(REQ_ENTER, valid_cat(), next_delta());
        if (gen_depth == 0)
          queue_event(REQ_EXIT, 0, next_delta());
      end else begin
        queue_event(REQ_CLEAR, $urandom_range(0, 7), next_delta());
      end
    end
  end

  // Idle/stall pattern: bursty stretches alternate with quiet ones
  bit src_busy  = 1'b1;
  bit sink_busy = 1'b1;
  int mode_cnt  = 0;

  always @(posedge clk) begin
    mode_cnt <= mode_cnt + 1;
    if (mode_cnt % 256 == 255) begin
      src_busy  <= ($urandom_range(0, 3) != 0);
      sink_busy <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic int pick_gap(input bit busy);
    int unsigned r;
    if (!busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Request driver; predicts each beat as it is taken
  int        src_gap = 0;
  prof_req_t drv_ev;
  prof_req_t took_ev;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        took_ev.req    = s_axis_tuser;
        took_ev.cat    = s_axis_tdata[CAT_W-1:0];
        took_ev.now_us = s_axis_tdata[CAT_W+TIME_W-1:CAT_W];
        expected_reports.push_back(profile_event(took_ev));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          drv_ev = pending_events.pop_front();
          s_axis_tdata  <= {{(IN_DATA_W-CAT_W-TIME_W){1'b0}}, drv_ev.now_us, drv_ev.cat};
          s_axis_tuser  <= drv_ev.req;
          s_axis_tvalid <= 1'b1;
          src_gap = pick_gap(src_busy);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Report monitor with random back-pressure
  int           sink_stall = 0;
  prof_report_t got_rep;
  prof_report_t want_rep;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_rep = m_axis_tdata;
        n_reports++;
        if (expected_reports.size() == 0) begin
          $display("%0t: report beat with none expected, actual %0h", $time, got_rep);
          mismatches++;
        end else begin
          want_rep = expected_reports.pop_front();
          check_field("report_category", want_rep.report_category, got_rep.report_category);
          check_field("total_time", want_rep.total_time, got_rep.total_time);
          check_field("call_count", want_rep.call_count, got_rep.call_count);
          check_field("max_time", want_rep.max_time, got_rep.max_time);
          check_field("frame_time", want_rep.frame_time, got_rep.frame_time);
          check_field("window_time", want_rep.window_time, got_rep.window_time);
          check_field("stack_level", want_rep.stack_level, got_rep.stack_level);
          check_field("overflow_count", want_rep.overflow_count, got_rep.overflow_count);
          check_field("accepted", want_rep.accepted, got_rep.accepted);
          if (want_rep.accepted) n_changes++;
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        sink_stall = pick_gap(sink_busy);
        m_axis_tready <= (sink_stall == 0);
      end
    end
  end

  // End of run: drain, let the pipeline settle, report
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    while (pending_events.size() > 0 || s_axis_tvalid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Checked %0d report beats, %0d of them state changes, %0d frame pops",
             n_reports, n_changes, n_pops);
    $display("Final predicted overflow count %0h, stack level %0d", refused_enters, open_cnt);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timeout waiting for report beats");
    $display("Mismatches found");
    $finish;
  end

endmodule
